// ===== rtl/tsw_pkg.sv =====
`timescale 1ns / 1ps
package tsw_pkg;
    localparam int MAX_DIM_DEF   = 256;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ADDR_W        = 16;
    localparam int DIM_W         = 9;
    localparam int COORD_W       = 32;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FILTER = 2'd2;

    typedef struct packed {
        logic        op;
        logic [15:0] texel_index;
        logic [7:0]  texel_red;
        logic [7:0]  texel_green;
        logic [7:0]  texel_blue;
        logic [7:0]  texel_alpha;
        logic signed [31:0] u_coord;
        logic signed [31:0] v_coord;
    } t_req;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_res;

    // store write from the load path
    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [31:0]         data;
    } t_wr;

    // four fetch addresses and control for one sample
    typedef struct packed {
        logic                vld;
        logic                bilin;
        logic [ADDR_W-1:0]   a_addr;
        logic [ADDR_W-1:0]   b_addr;
        logic [ADDR_W-1:0]   c_addr;
        logic [ADDR_W-1:0]   d_addr;
    } t_fetch;
endpackage

// ===== rtl/texture_sampler_wrap_bilinear_unit.sv =====
`timescale 1ns / 1ps
// Texture sampler, repeat wrap, nearest or bilinear. One request per cycle;
// busy is never raised. A sample returns its result with o_done after four
// coordinate stages, one store read and three blend stages. A load passes
// through a delay line and reaches the store in step with the fetch addresses
// of samples, so every sample sees exactly the loads accepted before it, back
// to back included. Results cannot be held off.
module texture_sampler_wrap_bilinear_unit
    import tsw_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_res        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int WR_DLY = 4;

    logic [DIM_W-1:0] r_w, r_h;
    logic             r_mode;
    logic [1:0]       reg_sel;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign reg_sel = paddr[3:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= DIM_W'(256);
            r_h    <= DIM_W'(256);
            r_mode <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_WIDTH:  r_w    <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_h    <= pwdata[DIM_W-1:0];
                REG_FILTER: r_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_WIDTH:  prdata = 32'(r_w);
            REG_HEIGHT: prdata = 32'(r_h);
            REG_FILTER: prdata = 32'(r_mode);
            default:    prdata = '0;
        endcase
    end

    // hold the load request until it lines up with the fetch stage
    t_wr r_wr [WR_DLY];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WR_DLY; k++) r_wr[k].en <= 1'b0;
        end else begin
            r_wr[0].en <= start && (i_req.op == OP_LOAD);
            for (int k = 1; k < WR_DLY; k++) r_wr[k].en <= r_wr[k-1].en;
        end
        r_wr[0].addr <= i_req.texel_index;
        r_wr[0].data <= {i_req.texel_alpha, i_req.texel_blue,
                         i_req.texel_green, i_req.texel_red};
        for (int k = 1; k < WR_DLY; k++) begin
            r_wr[k].addr <= r_wr[k-1].addr;
            r_wr[k].data <= r_wr[k-1].data;
        end
    end

    t_fetch               fetch;
    logic [FRAC_BITS-1:0] fu, fv, r_fu, r_fv;
    logic                 r_fvld, r_fbil;
    logic [31:0]          ta, tb, tc, td;

    tsw_addr #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_addr (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_vld(start && (i_req.op == OP_SAMPLE)),
        .i_u(i_req.u_coord), .i_v(i_req.v_coord),
        .i_w(r_w), .i_h(r_h), .i_bilin(r_mode),
        .o_fetch(fetch), .o_fu(fu), .o_fv(fv)
    );

    tsw_store u_store (
        .i_clk(i_clk), .i_wr(r_wr[WR_DLY-1]), .i_fetch(fetch),
        .o_a(ta), .o_b(tb), .o_c(tc), .o_d(td)
    );

    // advance control alongside the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fvld <= 1'b0;
        else r_fvld <= fetch.vld;
        r_fbil <= fetch.bilin;
        r_fu   <= fu;
        r_fv   <= fv;
    end

    tsw_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_vld(r_fvld), .i_bilin(r_fbil), .i_fu(r_fu), .i_fv(r_fv),
        .i_a(ta), .i_b(tb), .i_c(tc), .i_d(td),
        .o_vld(o_done), .o_res(o_res)
    );
endmodule

// ===== rtl/tsw_addr.sv =====
`timescale 1ns / 1ps
// Coordinate stages: scale, split into cell and weight, wrap, form addresses.
module tsw_addr
    import tsw_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [COORD_W-1:0]   i_u,
    input  logic [COORD_W-1:0]   i_v,
    input  logic [DIM_W-1:0]     i_w,
    input  logic [DIM_W-1:0]     i_h,
    input  logic                 i_bilin,
    output t_fetch               o_fetch,
    output logic [FRAC_BITS-1:0] o_fu,
    output logic [FRAC_BITS-1:0] o_fv
);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int CW = $clog2(MAX_DIM);
    localparam int PW = FRAC_BITS + DW;
    localparam int SW = PW + 1;
    localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

    // effective dimensions
    logic [DW-1:0] w_eff, h_eff;
    always_comb begin
        if (i_w == '0) w_eff = DW'(1);
        else if (32'(i_w) > 32'(MAX_DIM)) w_eff = DW'(MAX_DIM);
        else w_eff = DW'(i_w);
        if (i_h == '0) h_eff = DW'(1);
        else if (32'(i_h) > 32'(MAX_DIM)) h_eff = DW'(MAX_DIM);
        else h_eff = DW'(i_h);
    end

    // stage 1: scale the fractions by the dimensions.
    // The whole part of a coordinate adds a multiple of the dimension to the
    // cell index, so only the fraction matters once the index is wrapped.
    logic                 r1_vld, r1_bil;
    logic [PW-1:0]        r1_pu, r1_pv, r1_pg;
    logic [DW-1:0]        r1_w, r1_h;
    logic [FRAC_BITS-1:0] fu_in, fv_in;
    logic [FRAC_BITS:0]   g_in;
    assign fu_in = i_u[FRAC_BITS-1:0];
    assign fv_in = i_v[FRAC_BITS-1:0];
    assign g_in  = ((FRAC_BITS+1)'(1) << FRAC_BITS) - (FRAC_BITS+1)'(fv_in);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else r1_vld <= i_vld;
        r1_bil <= i_bilin;
        r1_w   <= w_eff;
        r1_h   <= h_eff;
        r1_pu  <= PW'(fu_in * w_eff);
        r1_pv  <= PW'(fv_in * h_eff);
        r1_pg  <= PW'(g_in * h_eff);
    end

    // stage 2: shift by half a texel and split into cell and weight;
    // the cell lies in -1 .. n-1. Clamp the nearest cell.
    logic [SW-1:0] su, sv;
    logic [DW-1:0] nx_c, ny_c;
    assign su = {1'b0, r1_pu} - HALF;
    assign sv = {1'b0, r1_pv} - HALF;

    always_comb begin
        nx_c = r1_pu[PW-1:FRAC_BITS] > r1_w - DW'(1)
             ? r1_w - DW'(1) : r1_pu[PW-1:FRAC_BITS];
        ny_c = r1_pg[PW-1:FRAC_BITS] > r1_h - DW'(1)
             ? r1_h - DW'(1) : r1_pg[PW-1:FRAC_BITS];
    end

    logic                 r2_vld, r2_bil;
    logic [DW:0]          r2_kx, r2_ky;
    logic [FRAC_BITS-1:0] r2_fu, r2_fv;
    logic [DW-1:0]        r2_w, r2_h;
    logic [CW-1:0]        r2_nx, r2_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else r2_vld <= r1_vld;
        r2_bil <= r1_bil;
        r2_kx  <= su[SW-1:FRAC_BITS];
        r2_ky  <= sv[SW-1:FRAC_BITS];
        r2_fu  <= su[FRAC_BITS-1:0];
        r2_fv  <= sv[FRAC_BITS-1:0];
        r2_w   <= r1_w;
        r2_h   <= r1_h;
        r2_nx  <= CW'(nx_c);
        r2_ny  <= CW'(ny_c);
    end

    // stage 3: bilinear wraps the cells and their neighbours, flips v; nearest passes its cell
    logic [DW-1:0] mu, mu1, mv, mv1;
    always_comb begin
        mu  = r2_kx[DW] ? r2_w - DW'(1) : r2_kx[DW-1:0];
        mv  = r2_ky[DW] ? r2_h - DW'(1) : r2_ky[DW-1:0];
        mu1 = (mu + DW'(1) == r2_w) ? '0 : mu + DW'(1);
        mv1 = (mv + DW'(1) == r2_h) ? '0 : mv + DW'(1);
    end

    logic                 r3_vld, r3_bil;
    logic [CW-1:0]        r3_x0, r3_x1, r3_y0, r3_y1;
    logic [DW-1:0]        r3_w;
    logic [FRAC_BITS-1:0] r3_fu, r3_fv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else r3_vld <= r2_vld;
        r3_bil <= r2_bil;
        r3_w   <= r2_w;
        r3_fu  <= r2_fu;
        r3_fv  <= r2_fv;
        if (r2_bil) begin
            r3_x0 <= CW'(mu);
            r3_x1 <= CW'(mu1);
            r3_y0 <= CW'(r2_h - DW'(1) - mv);
            r3_y1 <= CW'(r2_h - DW'(1) - mv1);
        end else begin
            r3_x0 <= r2_nx;
            r3_x1 <= r2_nx;
            r3_y0 <= r2_ny;
            r3_y1 <= r2_ny;
        end
    end

    // stage 4: addresses
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_fetch.vld <= 1'b0;
        else o_fetch.vld <= r3_vld;
        o_fetch.bilin  <= r3_bil;
        o_fetch.a_addr <= ADDR_W'(r3_y0 * r3_w + r3_x0);
        o_fetch.b_addr <= ADDR_W'(r3_y0 * r3_w + r3_x1);
        o_fetch.c_addr <= ADDR_W'(r3_y1 * r3_w + r3_x0);
        o_fetch.d_addr <= ADDR_W'(r3_y1 * r3_w + r3_x1);
        o_fu <= r3_fu;
        o_fv <= r3_fv;
    end
endmodule

// ===== rtl/tsw_store.sv =====
`timescale 1ns / 1ps
// Four banked copies of the texel store, one read port each.
module tsw_store
    import tsw_pkg::*;
(
    input  logic        i_clk,
    input  t_wr         i_wr,
    input  t_fetch      i_fetch,
    output logic [31:0] o_a,
    output logic [31:0] o_b,
    output logic [31:0] o_c,
    output logic [31:0] o_d
);
    localparam int DEPTH = 1 << ADDR_W;
    logic [31:0] mem_a [DEPTH];
    logic [31:0] mem_b [DEPTH];
    logic [31:0] mem_c [DEPTH];
    logic [31:0] mem_d [DEPTH];

    // write all copies, read one address each
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem_a[i_wr.addr] <= i_wr.data;
            mem_b[i_wr.addr] <= i_wr.data;
            mem_c[i_wr.addr] <= i_wr.data;
            mem_d[i_wr.addr] <= i_wr.data;
        end
        o_a <= mem_a[i_fetch.a_addr];
        o_b <= mem_b[i_fetch.b_addr];
        o_c <= mem_c[i_fetch.c_addr];
        o_d <= mem_d[i_fetch.d_addr];
    end
endmodule

// ===== rtl/tsw_blend.sv =====
`timescale 1ns / 1ps
// Blend stages: horizontal lerp, vertical lerp, round and select.
module tsw_blend
    import tsw_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic                 i_bilin,
    input  logic [FRAC_BITS-1:0] i_fu,
    input  logic [FRAC_BITS-1:0] i_fv,
    input  logic [31:0]          i_a,
    input  logic [31:0]          i_b,
    input  logic [31:0]          i_c,
    input  logic [31:0]          i_d,
    output logic                 o_vld,
    output t_res                 o_res
);
    localparam int F1 = FRAC_BITS + 1;
    localparam int TW = 8 + F1;
    localparam int SW = TW + F1;

    logic [F1-1:0] wu1, wu0, wv1, wv0;
    assign wu1 = F1'(i_fu);
    assign wu0 = (F1'(1) << FRAC_BITS) - wu1;

    // horizontal
    logic              r1_vld, r1_bil;
    logic [TW-1:0]     r1_top [4];
    logic [TW-1:0]     r1_bot [4];
    logic [F1-1:0]     r1_wv1;
    logic [31:0]       r1_a;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else r1_vld <= i_vld;
        r1_bil <= i_bilin;
        r1_wv1 <= F1'(i_fv);
        r1_a   <= i_a;
        for (int k = 0; k < 4; k++) begin
            r1_top[k] <= TW'(i_a[8*k +: 8] * wu0) + TW'(i_b[8*k +: 8] * wu1);
            r1_bot[k] <= TW'(i_c[8*k +: 8] * wu0) + TW'(i_d[8*k +: 8] * wu1);
        end
    end

    assign wv1 = r1_wv1;
    assign wv0 = (F1'(1) << FRAC_BITS) - wv1;

    // vertical
    logic          r2_vld, r2_bil;
    logic [SW-1:0] r2_sum [4];
    logic [31:0]   r2_a;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else r2_vld <= r1_vld;
        r2_bil <= r1_bil;
        r2_a   <= r1_a;
        for (int k = 0; k < 4; k++)
            r2_sum[k] <= SW'(r1_top[k] * wv0) + SW'(r1_bot[k] * wv1)
                         + (SW'(1) << (2*FRAC_BITS - 1));
    end

    // round and select
    logic [7:0] ch [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (!r2_bil) ch[k] = r2_a[8*k +: 8];
            else if (r2_sum[k][SW-1:2*FRAC_BITS] > (SW-2*FRAC_BITS)'(255)) ch[k] = 8'hFF;
            else ch[k] = 8'(r2_sum[k][SW-1:2*FRAC_BITS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_vld <= 1'b0;
        else o_vld <= r2_vld;
        o_res.red   <= ch[0];
        o_res.green <= ch[1];
        o_res.blue  <= ch[2];
        o_res.alpha <= ch[3];
    end
endmodule
